// ===== design/trace_set_stream_parser_macros.svh =====
// Assertion macros used by the trace-set parser checker.
`ifndef TRACE_SET_STREAM_PARSER_MACROS_SVH
`define TRACE_SET_STREAM_PARSER_MACROS_SVH

// Clocked implication, disabled while in reset.
`define TSSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define TSSP_NEVER(lbl, expr, msg) \
  `TSSP_ASSERT(lbl, !(expr), msg)

`endif

// ===== design/tssp_pkg.sv =====
// Shared constants and types of the trace-set stream parser.
package tssp_pkg;

  localparam int unsigned VALUE_BYTES = 8;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned INDEX_W     = 32;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_HEADER = 3'd0;
  localparam kind_t KIND_TITLE  = 3'd1;
  localparam kind_t KIND_DIN    = 3'd2;
  localparam kind_t KIND_DOUT   = 3'd3;
  localparam kind_t KIND_SAMPLE = 3'd4;

  localparam logic [7:0] TAG_NUM_TRACES  = 8'h41;
  localparam logic [7:0] TAG_NUM_SAMPLES = 8'h42;
  localparam logic [7:0] TAG_CODING      = 8'h43;
  localparam logic [7:0] TAG_DATA_LEN    = 8'h44;
  localparam logic [7:0] TAG_TITLE_LEN   = 8'h45;
  localparam logic [7:0] TAG_GLOBAL_TTL  = 8'h46;
  localparam logic [7:0] TAG_DESCRIPTION = 8'h47;
  localparam logic [7:0] TAG_OFFSET_X    = 8'h48;
  localparam logic [7:0] TAG_LABEL_X     = 8'h49;
  localparam logic [7:0] TAG_LABEL_Y     = 8'h4A;
  localparam logic [7:0] TAG_SCALE_X     = 8'h4B;
  localparam logic [7:0] TAG_SCALE_Y     = 8'h4C;
  localparam logic [7:0] TAG_TRACE_OFS   = 8'h4D;
  localparam logic [7:0] TAG_LOG_SCALE   = 8'h4E;
  localparam logic [7:0] TAG_HEADER_END  = 8'h5F;

  localparam logic [3:0] CODING_SIZE_MASK = 4'hF;
  localparam int unsigned CODING_FLOAT_BIT = 4;

endpackage

// ===== design/tssp_if.sv =====
// Byte input and result output stream interfaces of the trace-set parser.
interface tssp_in_if import tssp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       restart;

  modport source (output valid, output byte_in, output restart, input ready);
  modport sink   (input valid, input byte_in, input restart, output ready);
endinterface

interface tssp_out_if import tssp_pkg::*; ();
  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [7:0]         tag;
  logic [VALUE_W-1:0] value;
  logic [2:0]         sample_size;
  logic               is_float;
  logic [INDEX_W-1:0] trace_index;
  logic [INDEX_W-1:0] item_index;
  logic               last_of_trace;
  logic               last_of_set;

  modport source (
    output valid, output kind, output tag, output value, output sample_size,
    output is_float, output trace_index, output item_index,
    output last_of_trace, output last_of_set, input ready
  );
  modport sink (
    input valid, input kind, input tag, input value, input sample_size,
    input is_float, input trace_index, input item_index,
    input last_of_trace, input last_of_set, output ready
  );
endinterface

// ===== design/trace_set_stream_parser.sv =====
// Trace-set stream parser: one file byte per transaction in, at most one result out.
//
// in_i carries one byte of a trace-set file per transaction; restart marks the
// first tag byte of a new file and clears all parser state before that byte.
// out_o carries header values, title bytes, input and output data bytes and
// raw little-endian sample words, each with trace and item indices and the
// end-of-trace and end-of-set flags.
// Throughput is one byte per cycle: a byte is taken at every edge at which the
// result register is empty or being emptied, whether or not it yields a result.
// A result is registered: it shows on out_o in the cycle after the byte that
// completes it is taken, and stays until the receiver takes it.
// While the receiver stalls a full result register, in_i.ready is low and the
// byte stream is held back; no byte or result is dropped.
// Reset empties the result register and returns the parser to the header tag
// phase with all header fields and counters at zero.
// Bytes that follow the last trace of a set are taken and ignored until restart.
module trace_set_stream_parser import tssp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  tssp_in_if.sink     in_i,
  tssp_out_if.source  out_o
);

  typedef enum logic [3:0] {
    PH_TAG, PH_LEN, PH_VAL, PH_END, PH_TITLE, PH_DIN, PH_DOUT, PH_SAMP, PH_DONE
  } phase_e;

  phase_e             phase_q, phase_d, cur_phase;
  logic [7:0]         tag_q, tag_d, cur_tag;
  logic [7:0]         left_q, left_d, cur_left;
  logic [7:0]         pos_q, pos_d, cur_pos;
  logic [VALUE_W-1:0] acc_q, acc_d, cur_acc;
  logic [31:0]        ntr_q, ntr_d, cur_ntr;
  logic [31:0]        nsamp_q, nsamp_d, cur_nsamp;
  logic [7:0]         coding_q, coding_d, cur_coding;
  logic [15:0]        dlen_q, dlen_d, cur_dlen;
  logic [7:0]         tlen_q, tlen_d, cur_tlen;
  logic [31:0]        trace_q, trace_d, cur_trace;
  logic [31:0]        item_q, item_d, cur_item;

  logic               ovalid_q;
  kind_t              kind_q, r_kind;
  logic [7:0]         otag_q, r_tag;
  logic [VALUE_W-1:0] value_q, r_value;
  logic [2:0]         size_q, r_size;
  logic               flt_q, r_flt;
  logic [31:0]        tidx_q, r_tidx;
  logic [31:0]        iidx_q, r_iidx;
  logic               lt_q, r_lt;
  logic               ls_q, r_ls;
  logic               emit;

  logic               in_acc;
  logic               restart;
  logic [7:0]         b;

  logic               ne_title, ne_data, ne_samp;
  phase_e             from_din, from_dout, from_samp, from_title, after_cur;
  logic [2:0]         samp_sz;
  logic [31:0]        sec_items, fin_cnt, fin_trace;
  logic               fin_wrap, fin_last;
  logic [7:0]         pos_n;
  logic [VALUE_W-1:0] lane, acc_hdr, acc_smp;
  logic               hdr_done;
  logic [VALUE_W-1:0] hdr_val;

  function automatic logic tag_known(logic [7:0] t);
    logic k;
    unique case (t)
      TAG_NUM_TRACES, TAG_NUM_SAMPLES, TAG_CODING, TAG_DATA_LEN, TAG_TITLE_LEN,
      TAG_GLOBAL_TTL, TAG_DESCRIPTION, TAG_OFFSET_X, TAG_LABEL_X, TAG_LABEL_Y,
      TAG_SCALE_X, TAG_SCALE_Y, TAG_TRACE_OFS, TAG_LOG_SCALE: k = 1'b1;
      default:                                                k = 1'b0;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] tag_fixed_len(logic [7:0] t);
    logic [7:0] n;
    unique case (t)
      TAG_NUM_TRACES, TAG_NUM_SAMPLES, TAG_OFFSET_X, TAG_SCALE_X, TAG_SCALE_Y,
      TAG_TRACE_OFS:                             n = 8'd4;
      TAG_DATA_LEN:                              n = 8'd2;
      TAG_CODING, TAG_TITLE_LEN, TAG_LOG_SCALE:  n = 8'd1;
      default:                                   n = 8'd0;
    endcase
    return n;
  endfunction

  assign b       = in_i.byte_in;
  assign restart = in_i.restart;
  assign in_i.ready = !ovalid_q || out_o.ready;
  assign in_acc  = in_i.valid && in_i.ready;

  assign cur_phase  = restart ? PH_TAG : phase_q;
  assign cur_tag    = restart ? '0 : tag_q;
  assign cur_left   = restart ? '0 : left_q;
  assign cur_pos    = restart ? '0 : pos_q;
  assign cur_acc    = restart ? '0 : acc_q;
  assign cur_ntr    = restart ? '0 : ntr_q;
  assign cur_nsamp  = restart ? '0 : nsamp_q;
  assign cur_coding = restart ? '0 : coding_q;
  assign cur_dlen   = restart ? '0 : dlen_q;
  assign cur_tlen   = restart ? '0 : tlen_q;
  assign cur_trace  = restart ? '0 : trace_q;
  assign cur_item   = restart ? '0 : item_q;

  always_comb begin
    unique case (cur_coding[3:0] & CODING_SIZE_MASK)
      4'd1, 4'd2, 4'd4: samp_sz = cur_coding[2:0];
      default:          samp_sz = 3'd0;
    endcase
  end

  assign ne_title = (cur_tlen != '0);
  assign ne_data  = (cur_dlen[15:1] != '0);
  assign ne_samp  = (samp_sz != '0) && (cur_nsamp != '0);

  assign from_samp  = ne_samp ? PH_SAMP : PH_DONE;
  assign from_dout  = ne_data ? PH_DOUT : from_samp;
  assign from_din   = ne_data ? PH_DIN  : from_samp;
  assign from_title = ne_title ? PH_TITLE : from_din;

  always_comb begin
    unique case (cur_phase)
      PH_TITLE: begin
        after_cur = from_din;
        sec_items = {24'd0, cur_tlen};
      end
      PH_DIN: begin
        after_cur = from_dout;
        sec_items = {17'd0, cur_dlen[15:1]};
      end
      PH_DOUT: begin
        after_cur = from_samp;
        sec_items = {17'd0, cur_dlen[15:1]};
      end
      PH_SAMP: begin
        after_cur = PH_DONE;
        sec_items = cur_nsamp;
      end
      default: begin
        after_cur = PH_DONE;
        sec_items = '0;
      end
    endcase
  end

  assign fin_cnt   = cur_item + 32'd1;
  assign fin_wrap  = (fin_cnt >= sec_items);
  assign fin_trace = cur_trace + 32'd1;
  assign fin_last  = (fin_trace >= cur_ntr);

  assign pos_n   = cur_pos + 8'd1;
  assign lane    = {{(VALUE_W-8){1'b0}}, b} << {cur_pos[2:0], 3'b000};
  assign acc_hdr = (cur_pos < 8'(VALUE_BYTES)) ? (cur_acc | lane) : cur_acc;
  assign acc_smp = (cur_pos < 8'd8) ? (cur_acc | lane) : cur_acc;

  always_comb begin
    phase_d  = cur_phase;
    tag_d    = cur_tag;
    left_d   = cur_left;
    pos_d    = cur_pos;
    acc_d    = cur_acc;
    ntr_d    = cur_ntr;
    nsamp_d  = cur_nsamp;
    coding_d = cur_coding;
    dlen_d   = cur_dlen;
    tlen_d   = cur_tlen;
    trace_d  = cur_trace;
    item_d   = cur_item;
    emit     = 1'b0;
    r_kind   = KIND_HEADER;
    r_tag    = '0;
    r_value  = '0;
    r_size   = '0;
    r_flt    = 1'b0;
    r_tidx   = '0;
    r_iidx   = '0;
    r_lt     = 1'b0;
    r_ls     = 1'b0;
    hdr_done = 1'b0;
    hdr_val  = '0;

    unique case (cur_phase)
      PH_TAG: begin
        if (b == TAG_HEADER_END) begin
          phase_d = PH_END;
        end else if (tag_known(b)) begin
          tag_d   = b;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        left_d = (tag_fixed_len(cur_tag) == '0) ? b : tag_fixed_len(cur_tag);
        acc_d  = '0;
        pos_d  = '0;
        if (left_d == '0) begin
          hdr_done = 1'b1;
          phase_d  = PH_TAG;
        end else begin
          phase_d = PH_VAL;
        end
      end
      PH_VAL: begin
        acc_d  = acc_hdr;
        pos_d  = pos_n;
        left_d = cur_left - 8'd1;
        if (left_d == '0) begin
          hdr_done = 1'b1;
          hdr_val  = acc_hdr;
          phase_d  = PH_TAG;
        end
      end
      PH_END: begin
        trace_d = '0;
        item_d  = '0;
        pos_d   = '0;
        acc_d   = '0;
        phase_d = (cur_ntr == '0) ? PH_DONE : from_title;
      end
      PH_TITLE, PH_DIN, PH_DOUT, PH_SAMP: begin
        if (cur_phase == PH_SAMP) begin
          acc_d = acc_smp;
          pos_d = pos_n;
        end
        if (cur_phase != PH_SAMP || pos_n >= {5'd0, samp_sz}) begin
          emit   = 1'b1;
          r_tidx = cur_trace;
          r_iidx = cur_item;
          if (cur_phase == PH_SAMP) begin
            r_kind  = KIND_SAMPLE;
            r_value = acc_smp;
            r_size  = samp_sz;
            r_flt   = cur_coding[CODING_FLOAT_BIT];
            acc_d   = '0;
            pos_d   = '0;
          end else begin
            r_kind  = (cur_phase == PH_TITLE) ? KIND_TITLE :
                      (cur_phase == PH_DIN)   ? KIND_DIN : KIND_DOUT;
            r_value = {{(VALUE_W-8){1'b0}}, b};
          end
          item_d = fin_cnt;
          if (fin_wrap) begin
            item_d  = '0;
            phase_d = after_cur;
            if (after_cur == PH_DONE) begin
              r_lt    = 1'b1;
              trace_d = fin_trace;
              if (fin_last) begin
                r_ls = 1'b1;
              end else begin
                phase_d = from_title;
              end
            end
          end
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_d = PH_DONE;
      end
    endcase

    if (hdr_done) begin
      emit    = 1'b1;
      r_kind  = KIND_HEADER;
      r_tag   = cur_tag;
      r_value = hdr_val;
      unique case (cur_tag)
        TAG_NUM_TRACES:  ntr_d    = hdr_val[31:0];
        TAG_NUM_SAMPLES: nsamp_d  = hdr_val[31:0];
        TAG_CODING:      coding_d = hdr_val[7:0];
        TAG_DATA_LEN:    dlen_d   = hdr_val[15:0];
        TAG_TITLE_LEN:   tlen_d   = hdr_val[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TAG;
      tag_q    <= '0;
      left_q   <= '0;
      pos_q    <= '0;
      acc_q    <= '0;
      ntr_q    <= '0;
      nsamp_q  <= '0;
      coding_q <= '0;
      dlen_q   <= '0;
      tlen_q   <= '0;
      trace_q  <= '0;
      item_q   <= '0;
      ovalid_q <= 1'b0;
      kind_q   <= KIND_HEADER;
      otag_q   <= '0;
      value_q  <= '0;
      size_q   <= '0;
      flt_q    <= 1'b0;
      tidx_q   <= '0;
      iidx_q   <= '0;
      lt_q     <= 1'b0;
      ls_q     <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q  <= phase_d;
        tag_q    <= tag_d;
        left_q   <= left_d;
        pos_q    <= pos_d;
        acc_q    <= acc_d;
        ntr_q    <= ntr_d;
        nsamp_q  <= nsamp_d;
        coding_q <= coding_d;
        dlen_q   <= dlen_d;
        tlen_q   <= tlen_d;
        trace_q  <= trace_d;
        item_q   <= item_d;
      end
      if (in_acc && emit) begin
        ovalid_q <= 1'b1;
        kind_q   <= r_kind;
        otag_q   <= r_tag;
        value_q  <= r_value;
        size_q   <= r_size;
        flt_q    <= r_flt;
        tidx_q   <= r_tidx;
        iidx_q   <= r_iidx;
        lt_q     <= r_lt;
        ls_q     <= r_ls;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.kind          = kind_q;
  assign out_o.tag           = otag_q;
  assign out_o.value         = value_q;
  assign out_o.sample_size   = size_q;
  assign out_o.is_float      = flt_q;
  assign out_o.trace_index   = tidx_q;
  assign out_o.item_index    = iidx_q;
  assign out_o.last_of_trace = lt_q;
  assign out_o.last_of_set   = ls_q;

endmodule

// ===== design/tssp_checker.sv =====
// Port-level assertion checker of the trace-set parser and its bind.
`include "trace_set_stream_parser_macros.svh"

module tssp_checker import tssp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input kind_t              kind_i,
  input logic [7:0]         tag_i,
  input logic [VALUE_W-1:0] value_i,
  input logic [2:0]         sample_size_i,
  input logic               is_float_i,
  input logic [INDEX_W-1:0] trace_index_i,
  input logic [INDEX_W-1:0] item_index_i,
  input logic               last_of_trace_i,
  input logic               last_of_set_i
);

  logic         out_stall;
  logic [144:0] res_bits;
  logic         hdr_bad;
  logic         smp_bad;

  assign out_stall = out_valid_i && !out_ready_i;
  assign res_bits  = {kind_i, tag_i, value_i, sample_size_i, is_float_i, trace_index_i,
                      item_index_i, last_of_trace_i, last_of_set_i};
  assign hdr_bad   = out_valid_i && kind_i == KIND_HEADER &&
                     (trace_index_i != '0 || item_index_i != '0 || sample_size_i != '0 ||
                      is_float_i || last_of_trace_i);
  assign smp_bad   = out_valid_i && kind_i == KIND_SAMPLE &&
                     !(sample_size_i == 3'd1 || sample_size_i == 3'd2 ||
                       sample_size_i == 3'd4);

  `TSSP_ASSERT(a_out_hold, out_stall |=> out_valid_i && $stable(res_bits), "result changed while stalled")
  `TSSP_NEVER(a_ready_free, !out_valid_i && !in_ready_i, "input blocked with empty result register")
  `TSSP_NEVER(a_set_end, out_valid_i && last_of_set_i && !last_of_trace_i, "set end without trace end")
  `TSSP_NEVER(a_hdr_fields, hdr_bad, "header result with trace fields")
  `TSSP_NEVER(a_smp_size, smp_bad, "sample with bad size")

endmodule

bind trace_set_stream_parser tssp_checker u_tssp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .kind_i          (out_o.kind),
  .tag_i           (out_o.tag),
  .value_i         (out_o.value),
  .sample_size_i   (out_o.sample_size),
  .is_float_i      (out_o.is_float),
  .trace_index_i   (out_o.trace_index),
  .item_index_i    (out_o.item_index),
  .last_of_trace_i (out_o.last_of_trace),
  .last_of_set_i   (out_o.last_of_set)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the trace-set stream parser: predicts and scores every result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tssp_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam int unsigned TRACE_BYTE_CAP = 96;
  localparam logic [7:0]  LEN_VARIABLE   = 8'h00;
  localparam logic [7:0]  LEN_UNKNOWN    = 8'hFF;

  typedef enum logic [3:0] {
    ST_TAG, ST_LENGTH, ST_VALUE, ST_HDR_END, ST_TITLE, ST_IN_DATA, ST_OUT_DATA, ST_SAMPLES,
    ST_FINISHED
  } parse_phase_e;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         tag;
    logic [VALUE_W-1:0] value;
    logic [2:0]         sample_size;
    logic               is_float;
    logic [INDEX_W-1:0] trace_index;
    logic [INDEX_W-1:0] item_index;
    logic               last_of_trace;
    logic               last_of_set;
  } parse_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tssp_in_if  in_if ();
  tssp_out_if out_if ();

  trace_set_stream_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Parser state mirrored by the predictor
  parse_phase_e st;
  logic [7:0]   rec_tag;
  logic [7:0]   rec_left;
  logic [7:0]   rec_pos;
  logic [63:0]  accum;
  logic [31:0]  trace_total;
  logic [31:0]  samples_total;
  logic [7:0]   coding_byte;
  logic [15:0]  data_bytes;
  logic [7:0]   title_bytes;
  logic [31:0]  trace_no;
  logic [31:0]  item_no;

  parse_result_t pending_results[$];
  logic [7:0]    file_bytes[$];

  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned files_sent = 0;
  int unsigned results_seen = 0;
  int unsigned kind_seen[5] = '{default: 0};
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] record_size(input logic [7:0] t);
    case (t)
      TAG_NUM_TRACES, TAG_NUM_SAMPLES, TAG_OFFSET_X, TAG_SCALE_X, TAG_SCALE_Y,
      TAG_TRACE_OFS: return 8'd4;
      TAG_DATA_LEN: return 8'd2;
      TAG_CODING, TAG_TITLE_LEN, TAG_LOG_SCALE: return 8'd1;
      TAG_GLOBAL_TTL, TAG_DESCRIPTION, TAG_LABEL_X, TAG_LABEL_Y: return LEN_VARIABLE;
      default: return LEN_UNKNOWN;
    endcase
  endfunction

  function automatic logic [2:0] sample_width();
    logic [3:0] s;
    s = coding_byte[3:0] & CODING_SIZE_MASK;
    return (s == 4'd1 || s == 4'd2 || s == 4'd4) ? s[2:0] : 3'd0;
  endfunction

  function automatic logic [31:0] section_size(input parse_phase_e sec);
    case (sec)
      ST_TITLE: return 32'(title_bytes);
      ST_IN_DATA, ST_OUT_DATA: return 32'(data_bytes >> 1);
      ST_SAMPLES: return (sample_width() != 3'd0) ? samples_total : 32'd0;
      default: return 32'd0;
    endcase
  endfunction

  function automatic parse_phase_e next_busy_section(input int from);
    for (int s = from; s <= int'(ST_SAMPLES); s++)
      if (section_size(parse_phase_e'(s)) != 32'd0) return parse_phase_e'(s);
    return ST_FINISHED;
  endfunction

  function automatic void clear_parser();
    st            = ST_TAG;
    rec_tag       = '0;
    rec_left      = '0;
    rec_pos       = '0;
    accum         = '0;
    trace_total   = '0;
    samples_total = '0;
    coding_byte   = '0;
    data_bytes    = '0;
    title_bytes   = '0;
    trace_no      = '0;
    item_no       = '0;
  endfunction

  function automatic void store_record();
    case (rec_tag)
      TAG_NUM_TRACES:  trace_total   = accum[31:0];
      TAG_NUM_SAMPLES: samples_total = accum[31:0];
      TAG_CODING:      coding_byte   = accum[7:0];
      TAG_DATA_LEN:    data_bytes    = accum[15:0];
      TAG_TITLE_LEN:   title_bytes   = accum[7:0];
      default: ;
    endcase
  endfunction

  // Advance past a completed byte or sample and flag the end of a trace or set
  function automatic void close_item(output logic end_trace, output logic end_set);
    end_trace = 1'b0;
    end_set   = 1'b0;
    item_no++;
    if (item_no < section_size(st)) return;
    item_no = '0;
    st = next_busy_section(int'(st) + 1);
    if (st != ST_FINISHED) return;
    end_trace = 1'b1;
    trace_no++;
    if (trace_no >= trace_total) begin
      end_set = 1'b1;
      st = ST_FINISHED;
    end else begin
      st = next_busy_section(int'(ST_TITLE));
    end
  endfunction

  function automatic bit predict_result(input logic [7:0] b, input logic restart,
                                        output parse_result_t res);
    logic       end_trace;
    logic       end_set;
    logic [2:0] width;
    res = '0;
    if (restart) clear_parser();
    case (st)
      ST_TAG: begin
        if (b == TAG_HEADER_END) begin
          st = ST_HDR_END;
        end else if (record_size(b) != LEN_UNKNOWN) begin
          rec_tag = b;
          st = ST_LENGTH;
        end
        return 1'b0;
      end
      ST_LENGTH: begin
        rec_left = (record_size(rec_tag) == LEN_VARIABLE) ? b : record_size(rec_tag);
        accum = '0;
        rec_pos = '0;
        if (rec_left != 8'd0) begin
          st = ST_VALUE;
          return 1'b0;
        end
        store_record();
        st = ST_TAG;
        res.kind = KIND_HEADER;
        res.tag = rec_tag;
        return 1'b1;
      end
      ST_VALUE: begin
        if (rec_pos < VALUE_BYTES && rec_pos < 8) accum |= 64'(b) << (8 * rec_pos);
        rec_pos++;
        rec_left--;
        if (rec_left != 8'd0) return 1'b0;
        store_record();
        st = ST_TAG;
        res.kind = KIND_HEADER;
        res.tag = rec_tag;
        res.value = accum;
        return 1'b1;
      end
      ST_HDR_END: begin
        trace_no = '0;
        item_no = '0;
        rec_pos = '0;
        accum = '0;
        st = (trace_total == 32'd0) ? ST_FINISHED : next_busy_section(int'(ST_TITLE));
        return 1'b0;
      end
      ST_TITLE, ST_IN_DATA, ST_OUT_DATA: begin
        res.kind = (st == ST_TITLE) ? KIND_TITLE : (st == ST_IN_DATA) ? KIND_DIN : KIND_DOUT;
        res.value = 64'(b);
        res.trace_index = trace_no;
        res.item_index = item_no;
        close_item(end_trace, end_set);
        res.last_of_trace = end_trace;
        res.last_of_set = end_set;
        return 1'b1;
      end
      ST_SAMPLES: begin
        width = sample_width();
        if (rec_pos < 8) accum |= 64'(b) << (8 * rec_pos);
        rec_pos++;
        if (rec_pos < width) return 1'b0;
        res.kind = KIND_SAMPLE;
        res.value = accum;
        res.sample_size = width;
        res.is_float = coding_byte[CODING_FLOAT_BIT];
        res.trace_index = trace_no;
        res.item_index = item_no;
        accum = '0;
        rec_pos = '0;
        close_item(end_trace, end_set);
        res.last_of_trace = end_trace;
        res.last_of_set = end_set;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic string describe(input parse_result_t r);
    return $sformatf("kind=%0d tag=%02h value=%016h size=%0d float=%b trace=%0d item=%0d eot=%b eos=%b",
                     r.kind, r.tag, r.value, r.sample_size, r.is_float, r.trace_index,
                     r.item_index, r.last_of_trace, r.last_of_set);
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("[%0t] %s", $realtime, msg);
  endfunction

  always @(posedge clk_i) begin
    parse_result_t fresh;
    parse_result_t oldest;
    parse_result_t observed;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        if (predict_result(in_if.byte_in, in_if.restart, fresh)) pending_results.push_back(fresh);
      end
      if (out_if.valid && out_if.ready) begin
        observed = '{out_if.kind, out_if.tag, out_if.value, out_if.sample_size, out_if.is_float,
                     out_if.trace_index, out_if.item_index, out_if.last_of_trace,
                     out_if.last_of_set};
        results_seen++;
        if (observed.kind <= KIND_SAMPLE) kind_seen[observed.kind]++;
        if (pending_results.size() == 0) begin
          note_failure({"unexpected result: ", describe(observed)});
        end else begin
          oldest = pending_results.pop_front();
          if (observed !== oldest)
            note_failure({"mismatch: expected ", describe(oldest), " got ", describe(observed)});
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("trace_set_stream_parser test failed");
      $finish;
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.byte_in <= b;
    in_if.restart <= restart;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_bytes[k]) send_byte(file_bytes[k], k == 0);
    files_sent++;
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic void add_record(input logic [7:0] t, input logic [63:0] v);
    logic [7:0] n;
    n = record_size(t);
    file_bytes.push_back(t);
    if (n == LEN_VARIABLE) begin
      n = ($urandom_range(39) == 0) ? 8'd255 : 8'($urandom_range(10));
      file_bytes.push_back(n);
      repeat (n) file_bytes.push_back(8'($urandom));
    end else begin
      file_bytes.push_back(8'($urandom));
      for (int k = 0; k < int'(n); k++) file_bytes.push_back(v[8*k +: 8]);
    end
  endfunction

  function automatic logic [31:0] mostly_small(input int unsigned hi, input logic [31:0] mask);
    return ($urandom_range(19) == 0) ? ($urandom & mask) : $urandom_range(hi);
  endfunction

  function automatic logic [7:0] unknown_tag();
    logic [7:0] t;
    do t = 8'($urandom);
    while (record_size(t) != LEN_UNKNOWN || t == TAG_HEADER_END);
    return t;
  endfunction

  // Build a file with a well-formed header and random trace bytes capped at TRACE_BYTE_CAP, occasionally cut short
  function automatic void build_random_file();
    logic [31:0]     traces;
    logic [31:0]     samples;
    logic [15:0]     dlen;
    logic [7:0]      title;
    logic [7:0]      coding;
    logic [7:0]      order[$];
    logic [7:0]      t;
    logic [3:0]      w;
    longint unsigned per_trace;
    longint unsigned trace_bytes;
    int unsigned     j;
    int unsigned     cut;
    traces  = mostly_small(3, 32'hFFFF_FFFF);
    samples = mostly_small(4, 32'hFFFF_FFFF);
    dlen    = 16'(mostly_small(7, 32'h0000_FFFF));
    title   = 8'(mostly_small(3, 32'h0000_00FF));
    coding[7:4] = 4'($urandom);
    case ($urandom_range(7))
      0, 1: coding[3:0] = 4'd1;
      2, 3: coding[3:0] = 4'd2;
      4, 5: coding[3:0] = 4'd4;
      default: coding[3:0] = 4'($urandom);
    endcase
    order = '{TAG_NUM_TRACES, TAG_NUM_SAMPLES, TAG_CODING, TAG_DATA_LEN, TAG_TITLE_LEN};
    for (int k = order.size() - 1; k > 0; k--) begin
      j = $urandom_range(k);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    file_bytes.delete();
    repeat ($urandom_range(3)) begin
      t = 8'(TAG_NUM_TRACES + $urandom_range(13));
      add_record(t, {$urandom, $urandom});
    end
    foreach (order[k]) begin
      if ($urandom_range(4) == 0) file_bytes.push_back(unknown_tag());
      case (order[k])
        TAG_NUM_TRACES:  add_record(order[k], 64'(traces));
        TAG_NUM_SAMPLES: add_record(order[k], 64'(samples));
        TAG_CODING:      add_record(order[k], 64'(coding));
        TAG_DATA_LEN:    add_record(order[k], 64'(dlen));
        default:         add_record(order[k], 64'(title));
      endcase
    end
    file_bytes.push_back(TAG_HEADER_END);
    file_bytes.push_back(8'($urandom));
    w = (coding[3:0] == 4'd1 || coding[3:0] == 4'd2 || coding[3:0] == 4'd4) ? coding[3:0] : 4'd0;
    per_trace = longint'(title) + 2 * longint'(dlen >> 1) + longint'(samples) * longint'(w);
    trace_bytes = per_trace * longint'(traces);
    if (trace_bytes > TRACE_BYTE_CAP) trace_bytes = TRACE_BYTE_CAP;
    repeat (int'(trace_bytes)) file_bytes.push_back(8'($urandom));
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endfunction

  task automatic test_basic_set();
    file_bytes = '{TAG_NUM_TRACES, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                   TAG_TITLE_LEN, 8'hFF, 8'h01,
                   TAG_DATA_LEN, 8'h00, 8'h03, 8'h00,
                   TAG_CODING, 8'h00, 8'h12,
                   TAG_NUM_SAMPLES, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                   TAG_GLOBAL_TTL, 8'h00,
                   TAG_HEADER_END, 8'hAA,
                   8'h00, 8'hFF, 8'h5A, 8'h80, 8'h3F};
    send_file();
  endtask

  task automatic test_empty_sets();
    file_bytes = '{8'hFF, TAG_HEADER_END, 8'h00, 8'h7E};
    send_file();
    file_bytes = '{TAG_NUM_TRACES, 8'hFF, 8'h02, 8'h00, 8'h00, 8'h00,
                   TAG_CODING, 8'h00, 8'h03, TAG_HEADER_END, 8'h00, TAG_NUM_TRACES};
    send_file();
    wait_for_results();
  endtask

  task automatic test_random_files(input int unsigned send_pct, input int unsigned recv_pct,
                                   input int unsigned target);
    int unsigned sent;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < target) begin
      file_bytes.delete();
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 16)) file_bytes.push_back(8'($urandom));
      end else begin
        build_random_file();
        sent += file_bytes.size();
      end
      send_file();
    end
    wait_for_results();
  endtask

  initial begin
    in_if.valid   <= 1'b0;
    in_if.byte_in <= '0;
    in_if.restart <= 1'b0;
    rst_ni        <= 1'b0;
    clear_parser();
    send_idle_pct = 25;
    recv_idle_pct = 61;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_set();
    test_empty_sets();
    test_random_files(25, 61, 250);
    test_random_files(61, 25, 250);
    test_random_files(0, 0, 250);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", pending_results.size()));
    $display("Covered %0d bytes in %0d files under three stall mixes, %0d results checked",
             bytes_sent, files_sent, results_seen);
    $display("Results by kind: header %0d, title %0d, input %0d, output %0d, sample %0d",
             kind_seen[KIND_HEADER], kind_seen[KIND_TITLE], kind_seen[KIND_DIN],
             kind_seen[KIND_DOUT], kind_seen[KIND_SAMPLE]);
    if (fail_count == 0) begin
      $display("trace_set_stream_parser test passed");
    end else begin
      $display("trace_set_stream_parser test failed");
    end
    $finish;
  end

endmodule
